FILE: hdl/ir_frame_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infrared frame receiver
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef IR_FRAME_RECEIVER_TOP_DEFINES_SVH
`define IR_FRAME_RECEIVER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define IRFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("irfr same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define IRFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("irfr next-cycle check failed");

`endif

FILE: hdl/irfr_pkg.sv
// ----------------------------------------------------------------------------
// Infrared frame receiver package
// Receiver modes, register indexes, store write bundle and default sizes.
// ----------------------------------------------------------------------------
package irfr_pkg;

  localparam int FRAME_BYTES_DEF = 4;
  localparam int TIMER_BITS_DEF  = 16;

  // Width of the byte counter and of the store index carried between modules.
  localparam int BIDX_W = 3;

  localparam logic [15:0] START_MIN_RST  = 16'd800;
  localparam logic [15:0] DATA_DELAY_RST = 16'd400;
  localparam logic [15:0] HOP_TIMEOUT_RST = 16'd1200;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_READY  = 3'd1,
    MODE_START  = 3'd2,
    MODE_SAMPLE = 3'd3,
    MODE_EDGE   = 3'd4,
    MODE_FULL   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_START_MIN   = 2'd1,
    CFG_DATA_DELAY  = 2'd2,
    CFG_HOP_TIMEOUT = 2'd3
  } cfg_idx_e;

  // One byte written into the frame store.
  typedef struct packed {
    logic              we;
    logic [BIDX_W-1:0] idx;
    logic [7:0]        data;
  } store_wr_t;

endpackage

FILE: hdl/ir_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Infrared frame receiver, top level
// Decodes a one-wire infrared frame from per-cycle line samples and ticks.
// ----------------------------------------------------------------------------
// Each input word is one sample of the infrared line together with a timer
// tick strobe and a read request, and each one yields exactly one output word
// carrying the receiver status and, when a read took a full frame, the frame
// itself. The block sustains one word per clock cycle: a word is captured in
// an input register, goes through the edge, counter and bit-assembly logic
// combinationally, and lands in the result register. The input side keeps
// accepting words while a result waits to be taken, and stalls only when
// both the input register and the result register are occupied and the
// waiting result is not being taken in that cycle. Configuration writes are
// registered in the cycle they are accepted and are expected only while
// the block is idle; the port never stalls. After reset the receiver is off
// until enable is written with 1.
// ----------------------------------------------------------------------------
`include "ir_frame_receiver_top_defines.svh"

module ir_frame_receiver_top #(
  parameter int FRAME_BYTES = irfr_pkg::FRAME_BYTES_DEF,
  parameter int TIMER_BITS  = irfr_pkg::TIMER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        line_level_i,
  input  logic        tick_i,
  input  logic        read_frame_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_valid_o,
  output logic [31:0] frame_data_o,
  output logic [2:0]  status_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Input register.
  logic in_valid_q;
  logic level_q, tick_q, read_q;

  // Result register.
  logic        out_valid_q;
  logic        frame_valid_q;
  logic [31:0] frame_data_q;
  logic [2:0]  status_q;

  logic                advance;
  logic                in_take;
  irfr_pkg::mode_e     mode_n;
  logic                frame_take;
  irfr_pkg::store_wr_t store_wr;
  logic [31:0]         frame_view;

  // The word in the input register moves on whenever the result register is
  // empty or is being emptied in this cycle.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      level_q <= line_level_i;
      tick_q  <= tick_i;
      read_q  <= read_frame_i;
    end
    if (advance) begin
      frame_valid_q <= frame_take;
      frame_data_q  <= frame_take ? frame_view : 32'd0;
      status_q      <= 3'(mode_n);
    end
  end

  irfr_ctrl #(
    .FrameBytes (FRAME_BYTES),
    .TimerBits  (TIMER_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .line_level_i (level_q),
    .tick_i       (tick_q),
    .read_frame_i (read_q),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_o       (mode_n),
    .frame_take_o (frame_take),
    .wr_o         (store_wr)
  );

  // The store is written only when a step actually advances.
  irfr_pkg::store_wr_t store_wr_gated;

  always_comb begin
    store_wr_gated    = store_wr;
    store_wr_gated.we = store_wr.we && advance;
  end

  irfr_frame_buf #(
    .FrameBytes (FRAME_BYTES)
  ) u_frame_buf (
    .clk_i   (clk_i),
    .wr_i    (store_wr_gated),
    .frame_o (frame_view)
  );

  assign out_valid_o   = out_valid_q;
  assign frame_valid_o = frame_valid_q;
  assign frame_data_o  = frame_data_q;
  assign status_o      = status_q;

  // A delivered frame always leaves the receiver ready for the next one.
  `IRFR_ASSERT_SAME(a_take_ready, out_valid_o && frame_valid_o, status_o == irfr_pkg::MODE_READY)
  // Frame data stays zero unless a frame was taken.
  `IRFR_ASSERT_SAME(a_data_zero, out_valid_o && !frame_valid_o, frame_data_o == 32'd0)
  // The input side stalls only with both registers full and the output held.
  `IRFR_ASSERT_SAME(a_stall_cause, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i)
  // A word that advances always produces a result in the next cycle.
  `IRFR_ASSERT_NEXT(a_advance_out, advance, out_valid_q)

endmodule

FILE: hdl/irfr_frame_buf.sv
// ----------------------------------------------------------------------------
// Infrared frame receiver frame store
// Holds the received bytes and presents the assembled frame, with the byte
// written in the current cycle already visible.
// ----------------------------------------------------------------------------
module irfr_frame_buf #(
  parameter int FrameBytes = irfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk_i,
  input  irfr_pkg::store_wr_t wr_i,
  output logic [31:0]         frame_o
);

  localparam int IdxW = (FrameBytes > 1) ? $clog2(FrameBytes) : 1;

  logic [7:0] store_q [FrameBytes];
  logic [7:0] view    [FrameBytes];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      store_q[wr_i.idx[IdxW-1:0]] <= wr_i.data;
    end
  end

  // The first byte lands in the most significant position; for long frames
  // only the last four bytes remain.
  always_comb begin
    frame_o = '0;
    for (int i = 0; i < FrameBytes; i++) begin
      view[i] = (wr_i.we && (wr_i.idx == irfr_pkg::BIDX_W'(i))) ? wr_i.data : store_q[i];
      frame_o = {frame_o[23:0], view[i]};
    end
  end

endmodule

FILE: hdl/irfr_ctrl.sv
// ----------------------------------------------------------------------------
// Infrared frame receiver control
// Mode machine, tick counter, bit assembly and configuration registers.
// ----------------------------------------------------------------------------
module irfr_ctrl #(
  parameter int FrameBytes = irfr_pkg::FRAME_BYTES_DEF,
  parameter int TimerBits  = irfr_pkg::TIMER_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                line_level_i,
  input  logic                tick_i,
  input  logic                read_frame_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output irfr_pkg::mode_e     mode_o,
  output logic                frame_take_o,
  output irfr_pkg::store_wr_t wr_o
);

  localparam int CmpW = ((TimerBits > 16) ? TimerBits : 16) + 1;
  localparam int BW   = irfr_pkg::BIDX_W;

  irfr_pkg::mode_e        mode_q, mode_d;
  logic                   prev_q;
  logic [TimerBits-1:0]   cnt_q, cnt_d, cnt_dec;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d, shift_smp;
  logic [BW-1:0]          bidx_q, bidx_d, bidx_inc;
  logic [15:0]            start_min_q, data_delay_q, hop_q;

  logic                   edge_seen, acted;
  logic [CmpW-1:0]        cnt_ext, lo_ext, hi_ext, dd_ext, hop_ext;

  assign edge_seen = (line_level_i != prev_q);
  assign cnt_ext   = CmpW'(cnt_q);
  assign lo_ext    = CmpW'(start_min_q);
  assign dd_ext    = CmpW'(data_delay_q);
  assign hop_ext   = CmpW'(hop_q);
  assign hi_ext    = lo_ext + dd_ext;
  assign cnt_dec   = (cnt_q != '0) ? (cnt_q - TimerBits'(1)) : cnt_q;
  assign shift_smp = shift_q | (8'(line_level_i) << (3'd7 - bit_q));
  assign bidx_inc  = bidx_q + BW'(1);

  // Edge first; a tick only counts when the edge left mode and counter alone.
  // The read request is handled last, so a frame completed by this cycle's
  // sample can already be taken.
  always_comb begin
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    bidx_d       = bidx_q;
    acted        = 1'b0;
    frame_take_o = 1'b0;
    wr_o         = '0;
    wr_o.idx     = bidx_q;
    wr_o.data    = shift_smp;

    if (edge_seen) begin
      if (mode_q == irfr_pkg::MODE_READY && !line_level_i) begin
        mode_d = irfr_pkg::MODE_START;
        cnt_d  = '0;
        acted  = 1'b1;
      end else if (mode_q == irfr_pkg::MODE_START && line_level_i) begin
        if (cnt_ext > lo_ext && cnt_ext < hi_ext) begin
          mode_d = irfr_pkg::MODE_SAMPLE;
          cnt_d  = dd_ext[TimerBits-1:0];
        end else begin
          mode_d = irfr_pkg::MODE_READY;
          cnt_d  = '0;
        end
        acted = 1'b1;
      end else if (mode_q == irfr_pkg::MODE_EDGE) begin
        mode_d = irfr_pkg::MODE_SAMPLE;
        cnt_d  = dd_ext[TimerBits-1:0];
        acted  = 1'b1;
      end
    end

    if (tick_i && !acted) begin
      if (mode_q == irfr_pkg::MODE_START) begin
        if (cnt_q != '1) begin
          cnt_d = cnt_q + TimerBits'(1);
        end
      end else if (mode_q == irfr_pkg::MODE_SAMPLE || mode_q == irfr_pkg::MODE_EDGE) begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          if (mode_q == irfr_pkg::MODE_SAMPLE) begin
            shift_d = shift_smp;
            if (bit_q == 3'd7) begin
              wr_o.we = (bidx_q < BW'(FrameBytes));
              bidx_d  = bidx_inc;
              if (bidx_inc >= BW'(FrameBytes)) begin
                mode_d = irfr_pkg::MODE_FULL;
              end else begin
                bit_d   = '0;
                shift_d = '0;
                mode_d  = irfr_pkg::MODE_EDGE;
                cnt_d   = hop_ext[TimerBits-1:0];
              end
            end else begin
              bit_d  = bit_q + 3'd1;
              mode_d = irfr_pkg::MODE_EDGE;
              cnt_d  = hop_ext[TimerBits-1:0];
            end
          end else begin
            mode_d  = irfr_pkg::MODE_READY;
            bit_d   = '0;
            shift_d = '0;
            bidx_d  = '0;
          end
        end
      end
    end

    if (read_frame_i && mode_d == irfr_pkg::MODE_FULL) begin
      frame_take_o = 1'b1;
      bit_d        = '0;
      shift_d      = '0;
      bidx_d       = '0;
      cnt_d        = '0;
      mode_d       = irfr_pkg::MODE_READY;
    end

    mode_o = mode_d;
  end

  // The receiver is enabled exactly when the mode is not off, so the enable
  // bit needs no register of its own.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= irfr_pkg::MODE_OFF;
      prev_q       <= 1'b1;
      cnt_q        <= '0;
      bit_q        <= '0;
      shift_q      <= '0;
      bidx_q       <= '0;
      start_min_q  <= irfr_pkg::START_MIN_RST;
      data_delay_q <= irfr_pkg::DATA_DELAY_RST;
      hop_q        <= irfr_pkg::HOP_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        irfr_pkg::CFG_ENABLE: begin
          if (!cfg_data_i[0] || mode_q == irfr_pkg::MODE_OFF) begin
            mode_q  <= cfg_data_i[0] ? irfr_pkg::MODE_READY : irfr_pkg::MODE_OFF;
            cnt_q   <= '0;
            bit_q   <= '0;
            shift_q <= '0;
            bidx_q  <= '0;
          end
        end
        irfr_pkg::CFG_START_MIN:   start_min_q  <= cfg_data_i;
        irfr_pkg::CFG_DATA_DELAY:  data_delay_q <= cfg_data_i;
        irfr_pkg::CFG_HOP_TIMEOUT: hop_q        <= cfg_data_i;
        default: ;
      endcase
    end else if (step_i) begin
      mode_q  <= mode_d;
      prev_q  <= line_level_i;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      bidx_q  <= bidx_d;
    end
  end

endmodule

FILE: test/irfr_frame_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver result checker
// Watches the sample, result and register channels of the infrared frame
// receiver, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module irfr_frame_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        line_level_i,
  input  logic        tick_i,
  input  logic        read_frame_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        frame_valid_i,
  input  logic [31:0] frame_data_i,
  input  logic [2:0]  status_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          frames_o
);

  typedef struct packed {
    logic        frame_valid;
    logic [31:0] frame_data;
    logic [2:0]  status;
  } rx_word_t;

  logic [15:0] start_min;
  logic [15:0] data_delay;
  logic [15:0] hop_timeout;

  irfr_pkg::mode_e mode;
  logic        prev_level;
  logic [15:0] tick_cnt;
  logic [2:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [2:0]  byte_idx;
  logic [7:0]  frame_mem [irfr_pkg::FRAME_BYTES_DEF];

  rx_word_t    predicted_words [$];
  rx_word_t    want;
  rx_word_t    seen;
  rx_word_t    next_word;
  int          mismatches;
  int          words_checked;
  int          frames_read;

  assign errors_o  = mismatches;
  assign pending_o = predicted_words.size();
  assign frames_o  = frames_read;

  task automatic clear_progress();
    bit_cnt  = '0;
    shifter  = '0;
    byte_idx = '0;
  endtask

  task automatic report(input string field, input logic [31:0] want_v, input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("frame_check: word %0d %s expected %0h got %0h",
               words_checked, field, want_v, got_v);
    end
  endtask

  // One sample word: the edge first, then the tick unless the edge acted,
  // then the read request.
  task automatic step_receiver(input logic lvl, input logic tk, input logic rd,
                               output rx_word_t w);
    logic        edge_seen;
    logic        acted;
    logic [16:0] win_hi;
    edge_seen  = (lvl != prev_level);
    acted      = 1'b0;
    w          = '0;
    prev_level = lvl;

    if (edge_seen) begin
      if (mode == irfr_pkg::MODE_READY && !lvl) begin
        mode     = irfr_pkg::MODE_START;
        tick_cnt = '0;
        acted    = 1'b1;
      end else if (mode == irfr_pkg::MODE_START && lvl) begin
        win_hi = {1'b0, start_min} + {1'b0, data_delay};
        if ({1'b0, tick_cnt} > {1'b0, start_min} && {1'b0, tick_cnt} < win_hi) begin
          mode     = irfr_pkg::MODE_SAMPLE;
          tick_cnt = data_delay;
        end else begin
          mode     = irfr_pkg::MODE_READY;
          tick_cnt = '0;
        end
        acted = 1'b1;
      end else if (mode == irfr_pkg::MODE_EDGE) begin
        mode     = irfr_pkg::MODE_SAMPLE;
        tick_cnt = data_delay;
        acted    = 1'b1;
      end
    end

    if (tk && !acted) begin
      if (mode == irfr_pkg::MODE_START) begin
        if (tick_cnt != '1) tick_cnt = tick_cnt + 16'd1;
      end else if (mode == irfr_pkg::MODE_SAMPLE || mode == irfr_pkg::MODE_EDGE) begin
        if (tick_cnt != '0) tick_cnt = tick_cnt - 16'd1;
        if (tick_cnt == '0) begin
          if (mode == irfr_pkg::MODE_SAMPLE) begin
            shifter[3'd7 - bit_cnt] = lvl;
            if (bit_cnt == 3'd7) begin
              if (byte_idx < irfr_pkg::FRAME_BYTES_DEF) frame_mem[byte_idx[1:0]] = shifter;
              byte_idx = byte_idx + 3'd1;
              if (byte_idx >= irfr_pkg::FRAME_BYTES_DEF) begin
                mode = irfr_pkg::MODE_FULL;
              end else begin
                bit_cnt  = '0;
                shifter  = '0;
                mode     = irfr_pkg::MODE_EDGE;
                tick_cnt = hop_timeout;
              end
            end else begin
              bit_cnt  = bit_cnt + 3'd1;
              mode     = irfr_pkg::MODE_EDGE;
              tick_cnt = hop_timeout;
            end
          end else begin
            mode = irfr_pkg::MODE_READY;
            clear_progress();
          end
        end
      end
    end

    if (rd && mode == irfr_pkg::MODE_FULL) begin
      w.frame_valid = 1'b1;
      w.frame_data  = {frame_mem[0], frame_mem[1], frame_mem[2], frame_mem[3]};
      clear_progress();
      tick_cnt = '0;
      mode     = irfr_pkg::MODE_READY;
    end
    w.status = mode;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_min   = irfr_pkg::START_MIN_RST;
      data_delay  = irfr_pkg::DATA_DELAY_RST;
      hop_timeout = irfr_pkg::HOP_TIMEOUT_RST;
      mode        = irfr_pkg::MODE_OFF;
      prev_level  = 1'b1;
      tick_cnt    = '0;
      clear_progress();
      for (int i = 0; i < irfr_pkg::FRAME_BYTES_DEF; i++) frame_mem[i] = '0;
      predicted_words.delete();
      mismatches    = 0;
      words_checked = 0;
      frames_read   = 0;
    end else begin
      // Results leave before new words enter, so pop ahead of the push.
      if (out_valid_i && out_ready_i) begin
        seen = '{frame_valid: frame_valid_i, frame_data: frame_data_i, status: status_i};
        if (predicted_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("frame_check: result word %0d arrived with nothing predicted",
                     words_checked);
          end
        end else begin
          want = predicted_words.pop_front();
          if (seen.frame_valid !== want.frame_valid)
            report("frame_valid", want.frame_valid, seen.frame_valid);
          if (seen.frame_data !== want.frame_data)
            report("frame_data", want.frame_data, seen.frame_data);
          if (seen.status !== want.status)
            report("status", want.status, seen.status);
          if (want.frame_valid) frames_read++;
        end
        words_checked++;
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (irfr_pkg::cfg_idx_e'(cfg_index_i))
          irfr_pkg::CFG_ENABLE: begin
            if (cfg_data_i[0]) begin
              if (mode == irfr_pkg::MODE_OFF) begin
                mode = irfr_pkg::MODE_READY;
                clear_progress();
                tick_cnt = '0;
              end
            end else begin
              mode = irfr_pkg::MODE_OFF;
              clear_progress();
              tick_cnt = '0;
            end
          end
          irfr_pkg::CFG_START_MIN:   start_min   = cfg_data_i;
          irfr_pkg::CFG_DATA_DELAY:  data_delay  = cfg_data_i;
          irfr_pkg::CFG_HOP_TIMEOUT: hop_timeout = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        step_receiver(line_level_i, tick_i, read_frame_i, next_word);
        predicted_words.push_back(next_word);
      end
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infrared frame receiver testbench
// Drives line samples, ticks and read requests into the receiver, writes its
// timing registers between phases and leaves prediction and comparison of
// every result word to the frame checker.
// ----------------------------------------------------------------------------
module tb_top;

  // The longest legal quiet stretch is the forced receiver hold-off plus a
  // few random stalls; anything far beyond that is a hang.
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 130;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        line_level = 1'b1;
  logic        tick       = 1'b0;
  logic        read_frame = 1'b0;
  logic        out_ready  = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_index  = irfr_pkg::CFG_ENABLE;
  logic [15:0] cfg_data   = '0;

  logic        in_ready;
  logic        out_valid;
  logic        frame_valid;
  logic [31:0] frame_data;
  logic [2:0]  status;
  logic        cfg_ready;

  int          errors;
  int          pending;
  int          frames_read;

  // Pacing knobs. The sender gap rate is read only by the stimulus process;
  // the receiver rate and hold-off requests are handed over by nonblocking
  // writes, which the receiver process picks up at its next clock edge.
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          filler_pct    = 15;
  int          hold_asks     = 0;
  int          hold_done     = 0;
  int          hold_left     = 0;
  int          stuck_cycles  = 0;

  // Stimulus-side copy of the timing registers and of the line level that
  // the last accepted word carried.
  int          start_min  = irfr_pkg::START_MIN_RST;
  int          data_delay = irfr_pkg::DATA_DELAY_RST;
  int          hop_ticks  = irfr_pkg::HOP_TIMEOUT_RST;
  logic        level_now  = 1'b1;
  int          words_sent = 0;

  ir_frame_receiver_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .line_level_i  (line_level),
    .tick_i        (tick),
    .read_frame_i  (read_frame),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .frame_valid_o (frame_valid),
    .frame_data_o  (frame_data),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  irfr_frame_check frame_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .line_level_i  (line_level),
    .tick_i        (tick),
    .read_frame_i  (read_frame),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .frame_valid_i (frame_valid),
    .frame_data_i  (frame_data),
    .status_i      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .pending_o     (pending),
    .frames_o      (frames_read)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side. A pending hold-off request turns into a long run of cycles
  // with ready low; otherwise ready follows the current stall rate.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      out_ready <= 1'b0;
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts clocks in which no channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic logic rare_read();
    return ($urandom_range(19) == 0);
  endfunction

  // Offers one sample word and returns at the clock edge that takes it.
  // Every task here starts and ends right after a rising edge; ready is
  // looked at on the falling edge, where nothing is changing.
  task automatic send_word(input logic lvl, input logic tk, input logic rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    line_level <= lvl;
    tick       <= tk;
    read_frame <= rd;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    level_now = lvl;
    words_sent++;
  endtask

  // Sends n ticks at a steady level, with tickless words mixed in.
  task automatic tick_run(input int n, input logic lvl);
    int left;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < filler_pct) begin
        send_word(lvl, 1'b0, rare_read());
      end else begin
        send_word(lvl, 1'b1, rare_read());
        left--;
      end
    end
  endtask

  // Lets every predicted result drain so the block is idle for a register
  // write, then waits a few more clocks.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input irfr_pkg::cfg_idx_e idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_timing(input int sm, input int dd, input int hop);
    settle();
    write_reg(irfr_pkg::CFG_START_MIN, sm[15:0]);
    write_reg(irfr_pkg::CFG_DATA_DELAY, dd[15:0]);
    write_reg(irfr_pkg::CFG_HOP_TIMEOUT, hop[15:0]);
    start_min  = sm;
    data_delay = dd;
    hop_ticks  = hop;
  endtask

  // One frame attempt: idle high, a low start pulse of pulse_n ticks, then
  // nbits data bits, most significant first. Each bit is set up so that the
  // line holds the bit value when the sample countdown runs out; between
  // bits an edge re-arms the countdown, and a further edge (ignored while a
  // sample is pending) fixes the level when the bit repeats. At bit cut the
  // line instead stays quiet until the hop timeout drops the frame. A full
  // frame is read out at the end.
  task automatic send_frame(input logic [31:0] bits, input int pulse_n, input int nbits,
                            input int cut);
    int   extra_max;
    logic b;
    extra_max = (hop_ticks > 4) ? 3 : hop_ticks - 1;
    repeat ($urandom_range(1, 3)) send_word(1'b1, 1'b0, rare_read());
    send_word(1'b0, 1'($urandom_range(1)), rare_read());
    tick_run(pulse_n, 1'b0);
    send_word(1'b1, 1'($urandom_range(1)), rare_read());
    for (int i = 0; i < nbits; i++) begin
      b = bits[31 - i];
      if (i != 0) begin
        if (i == cut) begin
          tick_run(hop_ticks, level_now);
          return;
        end
        tick_run($urandom_range(0, extra_max), level_now);
        send_word(!level_now, 1'($urandom_range(1)), rare_read());
      end
      if (level_now != b) send_word(b, 1'b0, rare_read());
      tick_run(data_delay, b);
    end
    if (nbits == 32) begin
      repeat ($urandom_range(0, 2)) send_word(level_now, 1'($urandom_range(1)), 1'b0);
      send_word(level_now, 1'($urandom_range(1)), 1'b1);
    end
  endtask

  // A random frame attempt: mostly well-formed frames with random content,
  // some with a start pulse that is too short or too long, and some that
  // stall mid-frame until the hop timeout discards them.
  task automatic random_frame();
    logic [31:0] bits;
    int          pick;
    int          sel;
    for (int j = 0; j < 4; j++) begin
      sel = $urandom_range(3);
      bits[8*j +: 8] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      send_frame(bits, $urandom_range(0, start_min), 0, -1);
    end else if (pick == 1) begin
      send_frame(bits, start_min + data_delay + $urandom_range(0, 2), 0, -1);
    end else begin
      send_frame(bits, start_min + 1 + $urandom_range(0, data_delay - 2), 32,
                 (pick == 2) ? $urandom_range(1, 31) : -1);
    end
  endtask

  initial begin
    int budget;
    // Reset is held low from the start and released once.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First pacing mix: the sender rarely idles, the receiver often stalls.
    send_idle_pct = 23;
    recv_idle_pct <= 87;

    // While the receiver is off, edges, ticks and reads change nothing.
    send_word(1'b1, 1'b1, 1'b1);
    send_word(1'b0, 1'b1, 1'b0);
    send_word(1'b1, 1'b0, 1'b1);
    send_word(1'b0, 1'b0, 1'b0);
    send_word(1'b1, 1'b1, 1'b0);

    apply_timing(2, 3, 4);
    write_reg(irfr_pkg::CFG_ENABLE, 16'd1);
    // A read with no full frame gives an empty result.
    send_word(1'b1, 1'b0, 1'b1);
    // Start pulses below and at the top end of the window are rejected.
    send_frame(32'h0, 1, 0, -1);
    send_frame(32'h0, 5, 0, -1);
    // A frame cut off three bits in by switching the receiver off, which
    // drops the partial frame; switching it back on gives a clean ready.
    send_frame(32'hA000_0000, 3, 3, -1);
    settle();
    write_reg(irfr_pkg::CFG_ENABLE, 16'd0);
    send_word(1'b0, 1'b1, 1'b1);
    send_word(1'b1, 1'b1, 1'b0);
    settle();
    write_reg(irfr_pkg::CFG_ENABLE, 16'd1);

    // Random part: three pacing mixes, two register settings in each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct <= 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct <= 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        // The first setting puts the start bound and the hop timeout at
        // their floor with the narrowest usable window.
        if (ph == 0 && sub == 0) begin
          apply_timing(0, 2, 1);
        end else begin
          apply_timing($urandom_range(0, 6), $urandom_range(2, 5), $urandom_range(1, 6));
        end
        write_reg(irfr_pkg::CFG_ENABLE, 16'd1);
        // With nobody idling, the receiver holds off for a long stretch while
        // words keep coming, so the block backs up and stalls its input.
        if (ph == 2 && sub == 0) hold_asks <= hold_asks + 1;
        budget = words_sent + PHASE_WORDS;
        while (words_sent < budget) begin
          repeat ($urandom_range(0, 3)) begin
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)), rare_read());
          end
          random_frame();
        end
      end
    end

    // Register extremes. At the top of the range no start pulse can qualify;
    // a one-tick delay leaves an empty start window.
    apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(32'h0, 3, 0, -1);
    apply_timing(0, 1, 1);
    send_frame(32'h0, 1, 0, -1);
    send_frame(32'h0, 0, 0, -1);

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d sample words and read %0d full frames under three pacing mixes,",
             words_sent, frames_read);
    $display("with a long result hold-off, cut and rejected frames and register extremes.");
    if (errors == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
